// File: hw/rtl/hist256_pkg.sv
// Shared constants, types and helpers for the 256-bin histogram unit.
package hist256_pkg;

   localparam int NUM_BINS    = 256;
   localparam int COUNT_WIDTH = 32;
   localparam int SAMPLE_W    = 8;
   localparam int OP_W        = 2;
   localparam int REPORT_W    = 32;
   localparam int ADDR_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   // compare width wide enough for both a sample value and NUM_BINS itself
   localparam int CMP_W       = ((ADDR_W > SAMPLE_W) ? ADDR_W : SAMPLE_W) + 1;
   // report clamp width: must hold the widest of the counter and REPORT_W + 1
   localparam int EXT_W       = (COUNT_WIDTH > REPORT_W) ? COUNT_WIDTH : REPORT_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_COUNT      = 2'd0,
      OP_READ       = 2'd1,
      OP_READ_CLEAR = 2'd2
   } op_type;

   typedef struct packed {
      logic                   sat;
      logic [COUNT_WIDTH-1:0] count;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } wr_port_type;

   typedef struct packed {
      logic                valid;
      logic [OP_W-1:0]     op;
      logic                in_range;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] idx;
   } stage_type;

   function automatic logic bin_in_range(input logic [SAMPLE_W-1:0] value);
      bin_in_range = CMP_W'(value) < CMP_W'(NUM_BINS);
   endfunction

   function automatic logic [REPORT_W-1:0] report_count(input logic [COUNT_WIDTH-1:0] cnt);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(cnt);
      report_count = (ext > EXT_W'({REPORT_W{1'b1}})) ? {REPORT_W{1'b1}} : ext[REPORT_W-1:0];
   endfunction

endpackage

// File: hw/rtl/hist256_if.sv
// Valid/ready channel interfaces for histogram requests and responses.
interface hist256_req_if
   import hist256_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [SAMPLE_W-1:0] sample_value;
   logic [SAMPLE_W-1:0] bin_index;

   modport source (output valid, operation, sample_value, bin_index, input ready);
   modport sink   (input valid, operation, sample_value, bin_index, output ready);
endinterface

interface hist256_rsp_if
   import hist256_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] bin_number;
   logic [REPORT_W-1:0] bin_count;
   logic                saturated;

   modport source (output valid, bin_number, bin_count, saturated, input ready);
   modport sink   (input valid, bin_number, bin_count, saturated, output ready);
endinterface

// File: hw/rtl/histogram_256_bins_unit.sv
// A read item is accepted into the stage register and its result is then registered
// in the response register; a stalled response register holds the item in the stage.
// Throughput: one item per cycle; the RAM read-modify-write loop is closed by a
// forwarding register, so only a stalled response register holds up new items.
// Count items give no response. Reset clears control state and marks all bins
// empty through per-bin valid bits; items are accepted right after reset.
module histogram_256_bins_unit
   import hist256_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   hist256_req_if.sink   req_ch,
   hist256_rsp_if.source rsp_ch
);

   stage_type           stage_ff, stage_in;
   logic                accept;
   logic [SAMPLE_W-1:0] sel_value;
   entry_type           rd_data;
   wr_port_type         wr;
   logic                done;
   logic                has_rsp;
   logic                out_free;
   logic [REPORT_W-1:0] rpt_count;
   logic                rpt_sat;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_number_ff, rsp_number_in;
   logic [REPORT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                rsp_sat_ff, rsp_sat_in;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !stage_ff.valid || done;
   assign accept       = req_ch.valid && req_ch.ready;
   assign sel_value    = (req_ch.operation == OP_COUNT) ? req_ch.sample_value
                                                        : req_ch.bin_index;

   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in.valid    = 1'b1;
         stage_in.op       = req_ch.operation;
         stage_in.in_range = bin_in_range(sel_value);
         stage_in.addr     = ADDR_W'(sel_value);
         stage_in.idx      = req_ch.bin_index;
      end else if (done) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   hist256_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (ADDR_W'(sel_value)),
      .wr      (wr),
      .rd_data (rd_data)
   );

   hist256_rmw u_rmw (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage_ff),
      .accept      (accept),
      .accept_addr (ADDR_W'(sel_value)),
      .rd_data     (rd_data),
      .out_free    (out_free),
      .done        (done),
      .has_rsp     (has_rsp),
      .wr          (wr),
      .rpt_count   (rpt_count),
      .rpt_sat     (rpt_sat)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_number_in = rsp_number_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_sat_in    = rsp_sat_ff;
      if (done && has_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_number_in = stage_ff.idx;
         rsp_count_in  = rpt_count;
         rsp_sat_in    = rpt_sat;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_number_ff <= rsp_number_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.bin_number = rsp_number_ff;
   assign rsp_ch.bin_count  = rsp_count_ff;
   assign rsp_ch.saturated  = rsp_sat_ff;

endmodule

// File: hw/rtl/hist256_store.sv
// Bin storage: synchronous RAM with registered read and per-bin valid bits.
module hist256_store
   import hist256_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  wr_port_type       wr,
   output entry_type         rd_data
);

   entry_type             mem [NUM_BINS];
   entry_type             mem_rd_ff;
   logic [NUM_BINS-1:0]   valid_ff;
   logic                  valid_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   // valid bits stand in for clearing the array at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         valid_rd_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            valid_rd_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = valid_rd_ff ? mem_rd_ff : '0;

endmodule

// File: hw/rtl/hist256_rmw.sv
// Modify stage: forwarding, saturating increment or clear, write-back and report.
module hist256_rmw
   import hist256_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  stage_type           stage,
   input  logic                accept,
   input  logic [ADDR_W-1:0]   accept_addr,
   input  entry_type           rd_data,
   input  logic                out_free,
   output logic                done,
   output logic                has_rsp,
   output wr_port_type         wr,
   output logic [REPORT_W-1:0] rpt_count,
   output logic                rpt_sat
);

   logic      fwd_valid_ff, fwd_valid_in;
   entry_type fwd_data_ff,  fwd_data_in;
   entry_type cur;
   entry_type incr;

   assign has_rsp = stage.valid && (stage.op == OP_READ || stage.op == OP_READ_CLEAR);
   assign done    = stage.valid && (!has_rsp || out_free);

   // a write landing on the edge the next item reads the same bin is missed by the RAM
   assign cur = fwd_valid_ff ? fwd_data_ff : rd_data;

   always_comb begin
      incr.count = (cur.count != '1) ? cur.count + COUNT_WIDTH'(1) : cur.count;
      incr.sat   = cur.sat | (incr.count == '1);
   end

   always_comb begin
      wr.en   = 1'b0;
      wr.addr = stage.addr;
      wr.data = '0;
      unique case (stage.op)
         OP_COUNT: begin
            wr.en   = done && stage.in_range;
            wr.data = incr;
         end
         OP_READ_CLEAR: begin
            wr.en   = done && stage.in_range;
            wr.data = '0;
         end
         default: begin
            wr.en = 1'b0;
         end
      endcase
   end

   assign rpt_count = stage.in_range ? report_count(cur.count) : '0;
   assign rpt_sat   = stage.in_range & cur.sat;

   always_comb begin
      fwd_valid_in = fwd_valid_ff;
      fwd_data_in  = fwd_data_ff;
      if (accept) begin
         fwd_valid_in = wr.en && (wr.addr == accept_addr);
         fwd_data_in  = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= fwd_data_in;
   end

endmodule

// File: hw/rtl/hist256_checker.sv
// Port-level assertions for the histogram unit, bound to the top level.
module hist256_checker
   import hist256_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [OP_W-1:0]     req_operation,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SAMPLE_W-1:0] rsp_bin_number,
   input logic [REPORT_W-1:0] rsp_bin_count,
   input logic                rsp_saturated
);

   logic req_is_read;
   assign req_is_read = req_valid && req_ready &&
                        (req_operation == OP_READ || req_operation == OP_READ_CLEAR);

   // a stalled response keeps its item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_number) &&
                                  $stable(rsp_bin_count) && $stable(rsp_saturated))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered right after reset");

   // a fresh response must be preceded by an accepted read item
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_is_read, 2))
      else $error("response without a matching read item");

   a_sat_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_bin_count == {REPORT_W{1'b1}})
      else $error("saturated bin reported below the maximum");

endmodule

bind histogram_256_bins_unit hist256_checker u_hist256_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_operation  (req_ch.operation),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_bin_number (rsp_ch.bin_number),
   .rsp_bin_count  (rsp_ch.bin_count),
   .rsp_saturated  (rsp_ch.saturated)
);

// File: bench/tb_histogram_256_bins_unit.sv
// Self-checking testbench for the 256-bin histogram unit.
`timescale 1ns / 100ps

module tb_histogram_256_bins_unit;
   import hist256_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS  = 450;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 8;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] index;
   } hist_item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] bin_number;
      logic [REPORT_W-1:0] bin_count;
      logic                saturated;
   } bin_report_type;

   logic clock;
   logic reset;

   hist256_req_if req_bus ();
   hist256_rsp_if rsp_bus ();

   histogram_256_bins_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // shadow copy of the bin table
   logic [COUNT_WIDTH-1:0] shadow_counts [NUM_BINS];
   logic                   shadow_sat    [NUM_BINS];

   hist_item_type  pending_items[$];
   bin_report_type expected_reports[$];

   hist_item_type next_item;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned idle_cycles;
   int unsigned phase_cycles;
   logic        calm_phase;
   int          error_count;
   int unsigned op_tally [4];
   int unsigned reports_checked;
   logic [REPORT_W-1:0] peak_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm_phase || r < 50)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Applies one item to the shadow table; returns 1 when a report is due.
   function automatic logic update_histogram(input hist_item_type item,
                                             output bin_report_type report);
      logic [COUNT_WIDTH-1:0] cnt_max;
      logic [63:0]            wide;
      logic                   sat;
      cnt_max = '1;
      wide    = '0;
      sat     = 1'b0;
      report  = '0;
      if (item.op == OP_COUNT) begin
         if (int'(item.sample) < NUM_BINS) begin
            if (shadow_counts[item.sample] != cnt_max)
               shadow_counts[item.sample] = shadow_counts[item.sample] + 1'b1;
            if (shadow_counts[item.sample] == cnt_max)
               shadow_sat[item.sample] = 1'b1;
         end
         return 1'b0;
      end
      if (item.op != OP_READ && item.op != OP_READ_CLEAR)
         return 1'b0;
      if (int'(item.index) < NUM_BINS) begin
         wide = 64'(shadow_counts[item.index]);
         sat  = shadow_sat[item.index];
         if (item.op == OP_READ_CLEAR) begin
            shadow_counts[item.index] = '0;
            shadow_sat[item.index]    = 1'b0;
         end
      end
      report.bin_number = item.index;
      report.bin_count  = (wide > 64'({REPORT_W{1'b1}})) ? {REPORT_W{1'b1}} : wide[REPORT_W-1:0];
      report.saturated  = sat;
      return 1'b1;
   endfunction

   function automatic hist_item_type make_item(input logic [OP_W-1:0] op,
                                               input logic [SAMPLE_W-1:0] sample,
                                               input logic [SAMPLE_W-1:0] index);
      hist_item_type item;
      item.op     = op;
      item.sample = sample;
      item.index  = index;
      return item;
   endfunction

   // Hot bins make counts pile up and put reads, clears and counts of one bin close together.
   function automatic logic [SAMPLE_W-1:0] pick_bin(input logic [SAMPLE_W-1:0] hot_base);
      if ($urandom_range(0, 99) < 60)
         return hot_base + SAMPLE_W'($urandom_range(0, 7));
      return SAMPLE_W'($urandom);
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left      <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left      <= gap_left - 1;
         end else if (pending_items.size() > 0) begin
            next_item = pending_items.pop_front();
            req_bus.operation    <= next_item.op;
            req_bus.sample_value <= next_item.sample;
            req_bus.bin_index    <= next_item.index;
            req_bus.valid        <= 1'b1;
            gap_left             <= pick_idle();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= pick_idle();
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Alternate between stretches with and without idling
   always @(posedge clock) begin
      if (reset) begin
         phase_cycles <= 0;
         calm_phase   <= 1'b0;
      end else if (phase_cycles == 0) begin
         phase_cycles <= $urandom_range(40, 200);
         calm_phase   <= ($urandom_range(0, 3) == 0);
      end else begin
         phase_cycles <= phase_cycles - 1;
      end
   end

   // Monitor: check results, then predict for the accepted item
   always @(posedge clock) begin
      hist_item_type  seen_item;
      bin_report_type want;
      bin_report_type fresh;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected result: bin_number %0d bin_count %0d saturated %0b",
                      rsp_bus.bin_number, rsp_bus.bin_count, rsp_bus.saturated);
               error_count = error_count + 1;
            end else begin
               want = expected_reports.pop_front();
               reports_checked = reports_checked + 1;
               if (rsp_bus.bin_number !== want.bin_number) begin
                  $error("bin_number: expected %0d, actual %0d", want.bin_number,
                         rsp_bus.bin_number);
                  error_count = error_count + 1;
               end
               if (rsp_bus.bin_count !== want.bin_count) begin
                  $error("bin_count: expected %0d, actual %0d", want.bin_count,
                         rsp_bus.bin_count);
                  error_count = error_count + 1;
               end
               if (rsp_bus.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, actual %0b", want.saturated,
                         rsp_bus.saturated);
                  error_count = error_count + 1;
               end
               if (want.bin_count > peak_count)
                  peak_count = want.bin_count;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_item.op     = req_bus.operation;
            seen_item.sample = req_bus.sample_value;
            seen_item.index  = req_bus.bin_index;
            op_tally[seen_item.op] = op_tally[seen_item.op] + 1;
            if (update_histogram(seen_item, fresh))
               expected_reports.push_back(fresh);
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [SAMPLE_W-1:0] hot_base;
      int unsigned         r;
      logic [OP_W-1:0]     op;

      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.operation    = OP_COUNT;
      req_bus.sample_value = '0;
      req_bus.bin_index    = '0;
      rsp_bus.ready        = 1'b0;
      error_count          = 0;
      reports_checked      = 0;
      peak_count           = '0;
      for (int i = 0; i < 4; i++)
         op_tally[i] = 0;
      for (int i = 0; i < NUM_BINS; i++) begin
         shadow_counts[i] = '0;
         shadow_sat[i]    = 1'b0;
      end

      // directed: field extremes, back-to-back hits on one bin, clear then recount
      pending_items.push_back(make_item(OP_READ,       8'h00, 8'h00));
      pending_items.push_back(make_item(OP_COUNT,      8'h00, 8'hFF));
      pending_items.push_back(make_item(OP_COUNT,      8'h00, 8'h00));
      pending_items.push_back(make_item(OP_COUNT,      8'h00, 8'h55));
      pending_items.push_back(make_item(OP_READ,       8'hFF, 8'h00));
      pending_items.push_back(make_item(OP_COUNT,      8'hFF, 8'h00));
      pending_items.push_back(make_item(OP_COUNT,      8'h55, 8'hAA));
      pending_items.push_back(make_item(OP_COUNT,      8'hAA, 8'h55));
      pending_items.push_back(make_item(OP_READ,       8'h00, 8'hFF));
      pending_items.push_back(make_item(OP_READ,       8'h00, 8'h55));
      pending_items.push_back(make_item(OP_READ,       8'h00, 8'hAA));
      pending_items.push_back(make_item(OP_UNUSED,     8'hFF, 8'hFF));
      pending_items.push_back(make_item(OP_UNUSED,     8'h00, 8'h00));
      pending_items.push_back(make_item(OP_READ_CLEAR, 8'hFF, 8'h00));
      pending_items.push_back(make_item(OP_READ,       8'h00, 8'h00));
      pending_items.push_back(make_item(OP_READ_CLEAR, 8'h00, 8'hFF));
      pending_items.push_back(make_item(OP_COUNT,      8'hFF, 8'h00));
      pending_items.push_back(make_item(OP_READ,       8'h00, 8'hFF));
      pending_items.push_back(make_item(OP_READ_CLEAR, 8'h00, 8'h55));
      pending_items.push_back(make_item(OP_COUNT,      8'h55, 8'h00));
      pending_items.push_back(make_item(OP_READ_CLEAR, 8'h00, 8'h55));
      pending_items.push_back(make_item(OP_READ,       8'h00, 8'h55));
      pending_items.push_back(make_item(OP_READ,       8'h00, 8'h7E));

      // random: mostly valid operations on a drifting set of hot bins
      hot_base = SAMPLE_W'($urandom);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 59)
            hot_base = SAMPLE_W'($urandom);
         r = $urandom_range(0, 99);
         if (r < 55)
            op = OP_COUNT;
         else if (r < 80)
            op = OP_READ;
         else if (r < 95)
            op = OP_READ_CLEAR;
         else
            op = OP_UNUSED;
         pending_items.push_back(make_item(op, pick_bin(hot_base), pick_bin(hot_base)));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (pending_items.size() > 0 || req_bus.valid || expected_reports.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_reports.size() > 0) begin
         $error("%0d results never arrived", expected_reports.size());
         error_count = error_count + 1;
      end

      $display("Run covered %0d count, %0d read, %0d read-clear and %0d unused-code items.",
               op_tally[OP_COUNT], op_tally[OP_READ], op_tally[OP_READ_CLEAR],
               op_tally[OP_UNUSED]);
      $display("%0d bin reports compared, largest count seen %0d, %0d mismatches.",
               reports_checked, peak_count, error_count);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
